// ===== design/assert_macros.svh =====
// Assertion helpers included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/stb_pkg.sv =====
package stb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SIDE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = POS_W;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_SIGNED = CFG_IDX_W'(1);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [SIDE_W-1:0] SIDE_EXACT = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LOWER = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_UPPER = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIDE_W-1:0] side;
        logic [POS_W-1:0]  count;
        logic              cmp_signed;
    } search_req_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } search_res_t;

endpackage

// ===== design/sorted_table_binary_search.sv =====
// Sorted-table binary search. Write transactions (command 0) store a key at
// entry_index and produce no result; search transactions (command 1) run a
// halving search over the first entries_in_use entries (saturated to the table
// depth) and return one result: the lower-bound position, the upper-bound
// position, or in exact mode the lower-bound position with found set only when
// that entry equals the key. Keys compare unsigned or as two's complement per
// compare_signed. A search runs at most ceil(log2(N+1)) probes, 11 for 1024 entries,
// where N is the number of entries in use; each probe is one registered read of
// the key memory followed by a compare. In exact mode it then reads the bound
// entry for the equality check if that entry is in use. The input stalls until
// the search hands its result to the output register, which holds a result while
// the downstream side stalls. Reading an entry that was never written gives an
// undefined answer.
`include "assert_macros.svh"

module sorted_table_binary_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [stb_pkg::IDX_W-1:0]       entry_index,
    input  logic [stb_pkg::KEY_W-1:0]       entry_value,
    input  logic [stb_pkg::KEY_W-1:0]       search_key,
    input  logic [stb_pkg::SIDE_W-1:0]      search_side,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [stb_pkg::POS_W-1:0]       position,
    output logic                            found,
    input  logic                            cfg_write,
    input  logic [stb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stb_pkg::*;

    logic [POS_W-1:0] entries_reg;
    logic             signed_reg;
    logic [POS_W-1:0] count;

    logic             in_accept;
    logic             wr_en;
    logic             start;
    search_req_t      req;
    search_res_t      res;
    logic             seq_idle;
    logic             res_valid;
    logic             res_ready;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [KEY_W-1:0] rd_data;

    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] position_reg;
    logic             found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
            signed_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENTRIES_IN_USE: entries_reg <= cfg_data[POS_W-1:0];
                REG_COMPARE_SIGNED: signed_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign count = (entries_reg > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH) : entries_reg;

    assign in_stall  = !seq_idle;
    assign in_accept = in_valid && !in_stall;
    assign wr_en     = in_accept && (command == CMD_WRITE)
                       && ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_DEPTH));
    assign start     = in_accept && (command == CMD_SEARCH);

    assign req.key        = search_key;
    assign req.side       = search_side;
    assign req.count      = count;
    assign req.cmp_signed = signed_reg;

    stb_key_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_index),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stb_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // The output register is free when empty or when its transaction leaves now.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            position_reg <= res.position;
            found_reg    <= res.found;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign found     = found_reg;

    `ASSERT_SAME(a_pos_in_range, clk, rst_n, out_valid_reg, position_reg <= count)
    `ASSERT_NEXT(a_search_blocks_input, clk, rst_n, start, in_stall)
    `ASSERT_NEXT(a_out_drains, clk, rst_n, out_valid_reg && !out_stall && !res_valid, !out_valid_reg)

endmodule

// ===== design/stb_key_ram.sv =====
module stb_key_ram (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [stb_pkg::IDX_W-1:0] wr_addr,
    input  logic [stb_pkg::KEY_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [stb_pkg::IDX_W-1:0] rd_addr,
    output logic [stb_pkg::KEY_W-1:0] rd_data
);
    import stb_pkg::*;

    logic [KEY_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/stb_search.sv =====
module stb_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  stb_pkg::search_req_t        req,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output stb_pkg::search_res_t        res,
    output logic                        rd_en,
    output logic [stb_pkg::IDX_W-1:0]   rd_addr,
    input  logic [stb_pkg::KEY_W-1:0]   rd_data
);
    import stb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_READ      = 5'b00010,
        S_CMP       = 5'b00100,
        S_EXACT_CMP = 5'b01000,
        S_DONE      = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic              found_reg, found_next;
    logic [KEY_W-1:0]  key_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [POS_W-1:0]  count_reg;
    logic              signed_reg;

    logic [POS_W-1:0]  span;
    logic [POS_W-1:0]  mid;
    logic [KEY_W-1:0]  entry_ord;
    logic [KEY_W-1:0]  key_ord;
    logic              go_right;

    // Flipping the sign bit turns a two's complement order into an unsigned one.
    assign entry_ord = {rd_data[KEY_W-1] ^ signed_reg, rd_data[KEY_W-2:0]};
    assign key_ord   = {key_reg[KEY_W-1] ^ signed_reg, key_reg[KEY_W-2:0]};
    assign go_right  = side_reg[1] ? (entry_ord <= key_ord) : (entry_ord < key_ord);

    assign span = hi_reg - lo_reg;
    assign mid  = lo_reg + (span >> 1);

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        found_next = found_reg;
        rd_en      = 1'b0;
        rd_addr    = mid[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = req.count;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    state_next = S_CMP;
                end
                else if (side_reg == SIDE_EXACT && lo_reg < count_reg)
                begin
                    // The search has converged; fetch the bound entry to check equality.
                    rd_addr    = lo_reg[IDX_W-1:0];
                    state_next = S_EXACT_CMP;
                end
                else
                begin
                    found_next = (side_reg != SIDE_EXACT);
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid + POS_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_READ;
            end
            S_EXACT_CMP:
            begin
                found_next = (entry_ord == key_ord);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        found_reg <= found_next;
        if (state_reg == S_IDLE && start)
        begin
            key_reg    <= req.key;
            side_reg   <= req.side;
            count_reg  <= req.count;
            signed_reg <= req.cmp_signed;
        end
    end

    assign idle         = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res.position = lo_reg;
    assign res.found    = found_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import stb_pkg::*;

    // Side code 3 has no name in the package; the block treats it as an upper bound.
    localparam logic [SIDE_W-1:0] SIDE_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [IDX_W-1:0]      entry_index;
    logic [KEY_W-1:0]      entry_value;
    logic [KEY_W-1:0]      search_key;
    logic [SIDE_W-1:0]     search_side;
    logic                  out_valid;
    logic                  out_stall;
    logic [POS_W-1:0]      position;
    logic                  found;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [KEY_W-1:0]  key_shadow [TABLE_DEPTH];
    bit                written [TABLE_DEPTH];
    logic [POS_W-1:0]  shadow_count = '0;
    logic              shadow_signed = 1'b0;
    search_res_t       pending_results [$];
    int                mismatch_count = 0;
    int                random_items = 0;
    bit                idle_enable = 1'b1;

    sorted_table_binary_search i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("sorted_table_binary_search test failed");
        $finish;
    end

    // Maps a key so that a plain unsigned compare gives the configured ordering.
    function automatic logic [KEY_W-1:0] sort_order(logic [KEY_W-1:0] v);
        return shadow_signed ? {~v[KEY_W-1], v[KEY_W-2:0]} : v;
    endfunction

    function automatic search_res_t predict_search(logic [KEY_W-1:0] key,
                                                   logic [SIDE_W-1:0] side);
        search_res_t      res;
        int               span;
        int               lo;
        int               hi;
        int               mid;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] e;
        bit               upper;
        span  = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        upper = (side >= SIDE_UPPER);
        k     = sort_order(key);
        lo    = 0;
        hi    = span;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            e   = sort_order(key_shadow[mid]);
            if (upper ? (e <= k) : (e < k))
                lo = mid + 1;
            else
                hi = mid;
        end
        res.position = POS_W'(lo);
        if (side != SIDE_EXACT)
            res.found = 1'b1;
        else
            res.found = (lo < span) && (key_shadow[lo] == key);
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int n);
        logic [KEY_W-1:0] near;
        int               choice;
        near   = (n > 0) ? key_shadow[$urandom_range(0, n - 1)] : $urandom();
        choice = $urandom_range(0, 9);
        if (choice <= 3)
            return near;
        else if (choice == 4)
            return near + 1'b1;
        else if (choice == 5)
            return near - 1'b1;
        else if (choice == 6)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return {1'b1, {(KEY_W - 1){1'b0}}};
                default: return {1'b0, {(KEY_W - 1){1'b1}}};
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [SIDE_W-1:0] pick_side();
        return SIDE_W'($urandom_range(0, 3));
    endfunction

    // Keys of a strictly ascending ramp under the current compare mode.
    function automatic logic [KEY_W-1:0] ramp_key(int i);
        return KEY_W'(i * 4096 + 100) ^ (shadow_signed ? 32'h8000_0000 : 32'h0);
    endfunction

    function automatic logic [KEY_W-1:0] pick_ramp_key();
        logic [KEY_W-1:0] near;
        near = ramp_key($urandom_range(0, TABLE_DEPTH - 1));
        case ($urandom_range(0, 4))
            0:       return near + 1'b1;
            1:       return near - 1'b1;
            2:       return $urandom();
            default: return near;
        endcase
    endfunction

    // Leaves in_valid high after acceptance so that back-to-back transactions
    // never lower and raise it within one time step.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [KEY_W-1:0] value, input logic [KEY_W-1:0] key,
                             input logic [SIDE_W-1:0] side);
        int gap;
        gap = idle_enable ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_value <= value;
        search_key  <= key;
        search_side <= side;
        do
            @(posedge clk);
        while (in_stall);
        if (cmd == CMD_WRITE)
            key_shadow[idx] = value;
        else
            pending_results.push_back(predict_search(key, side));
    endtask

    task automatic store_entry(input int idx, input logic [KEY_W-1:0] value);
        send_item(CMD_WRITE, IDX_W'(idx), value, $urandom(), pick_side());
    endtask

    task automatic look_up(input logic [KEY_W-1:0] key, input logic [SIDE_W-1:0] side);
        send_item(CMD_SEARCH, IDX_W'($urandom()), $urandom(), key, side);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] count, input logic use_signed);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_ENTRIES_IN_USE;
        cfg_data  <= count;
        @(posedge clk);
        shadow_count = count;
        cfg_index <= REG_COMPARE_SIGNED;
        cfg_data  <= CFG_DATA_W'(use_signed);
        @(posedge clk);
        shadow_signed = use_signed;
        cfg_write <= 1'b0;
    endtask

    // Writes entries 0..n-1 in ascending order under the current compare mode,
    // with small steps now and then so that duplicate keys show up.
    task automatic fill_table(input int n);
        longint unsigned o;
        longint unsigned step_max;
        int              i;
        o = ($urandom_range(0, 3) == 0) ? 0 : ($urandom() >> $urandom_range(0, 31));
        step_max = (64'hFFFF_FFFF - o) / n;
        if ($urandom_range(0, 2) == 0 && step_max > 3)
            step_max = 3;
        for (i = 0; i < n; i++)
        begin
            store_entry(i, KEY_W'(o) ^ (shadow_signed ? 32'h8000_0000 : 32'h0));
            o += $urandom_range(0, 32'(step_max));
        end
    endtask

    // Writes, from the ramp, every entry that a search of key will probe, so a
    // search over the whole depth never touches an entry that was not written.
    task automatic prepare_path(input logic [KEY_W-1:0] key, input logic [SIDE_W-1:0] side);
        int               span;
        int               lo;
        int               hi;
        int               mid;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] e;
        bit               upper;
        span  = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        upper = (side >= SIDE_UPPER);
        k     = sort_order(key);
        lo    = 0;
        hi    = span;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (!written[mid])
            begin
                store_entry(mid, ramp_key(mid));
                written[mid] = 1'b1;
            end
            e = sort_order(key_shadow[mid]);
            if (upper ? (e <= k) : (e < k))
                lo = mid + 1;
            else
                hi = mid;
        end
        if (side == SIDE_EXACT && lo < span && !written[lo])
        begin
            store_entry(lo, ramp_key(lo));
            written[lo] = 1'b1;
        end
    endtask

    task automatic full_search();
        logic [KEY_W-1:0]  key;
        logic [SIDE_W-1:0] side;
        key  = pick_ramp_key();
        side = pick_side();
        prepare_path(key, side);
        look_up(key, side);
    endtask

    task automatic test_empty_table();
        look_up('1, SIDE_EXACT);
        look_up($urandom(), SIDE_LOWER);
        look_up('0, SIDE_UNUSED);
    endtask

    task automatic test_directed_edges();
        set_config(CFG_DATA_W'(4), 1'b0);
        store_entry(0, 32'h0000_0000);
        store_entry(1, 32'h0000_0005);
        store_entry(2, 32'h0000_0005);
        store_entry(3, 32'hFFFF_FFFF);
        look_up(32'h0000_0000, SIDE_EXACT);
        look_up(32'h0000_0005, SIDE_LOWER);
        look_up(32'h0000_0005, SIDE_UPPER);
        look_up(32'h0000_0006, SIDE_EXACT);
        look_up(32'hFFFF_FFFF, SIDE_UPPER);
        look_up(32'hFFFF_FFFF, SIDE_EXACT);
        look_up(32'h7FFF_FFFF, SIDE_UNUSED);
        // Two's complement order puts the most negative key first.
        set_config(CFG_DATA_W'(4), 1'b1);
        store_entry(0, 32'h8000_0000);
        store_entry(1, 32'hFFFF_FFFF);
        store_entry(2, 32'h0000_0000);
        store_entry(3, 32'h7FFF_FFFF);
        look_up(32'h8000_0000, SIDE_EXACT);
        look_up(32'h7FFF_FFFF, SIDE_UPPER);
        look_up(32'hFFFF_FFFF, SIDE_LOWER);
        look_up(32'h0000_0001, SIDE_EXACT);
        look_up(32'h0000_0000, SIDE_UPPER);
    endtask

    task automatic test_unsorted_table();
        int n;
        int j;
        n = $urandom_range(1, 30);
        set_config(CFG_DATA_W'(n), 1'($urandom_range(0, 1)));
        for (j = 0; j < n; j++)
            store_entry(j, $urandom());
        for (j = 0; j < 30; j++)
            look_up(pick_key(n), pick_side());
    endtask

    task automatic test_random_tables();
        int n;
        int count;
        int searches;
        int idx;
        int j;
        while (random_items < 300)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
            set_config(CFG_DATA_W'(count), 1'($urandom_range(0, 1)));
            idle_enable = ($urandom_range(0, 3) != 0);
            fill_table(n);
            searches = $urandom_range(10, 40);
            for (j = 0; j < searches; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // A stray write: either a harmless rewrite or one that may
                    // leave the table out of order.
                    idx = $urandom_range(0, TABLE_DEPTH - 1);
                    if (idx < n && $urandom_range(0, 1) == 0)
                        store_entry(idx, key_shadow[idx]);
                    else
                        store_entry(idx, $urandom());
                end
                else
                    look_up(pick_key(count), pick_side());
            end
            random_items += n + searches;
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_full_table();
        logic use_signed;
        int   j;
        use_signed = 1'($urandom_range(0, 1));
        for (j = 0; j < TABLE_DEPTH; j++)
            written[j] = 1'b0;
        set_config(CFG_DATA_W'(TABLE_DEPTH), use_signed);
        for (j = 0; j < 20; j++)
            full_search();
        // A count above the table depth must behave as the full table.
        set_config({CFG_DATA_W{1'b1}}, use_signed);
        for (j = 0; j < 10; j++)
            full_search();
        set_config(CFG_DATA_W'(TABLE_DEPTH - 1), use_signed);
        for (j = 0; j < 10; j++)
            full_search();
    endtask

    // Sink side stall: hold off a random number of cycles, then take one result.
    initial
    begin
        int n;
        forever
        begin
            n = idle_enable ? $urandom_range(0, 19) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        search_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: position %0d found %0b", position, found);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (position !== want.position || found !== want.found)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected pos %0d found %0b, got pos %0d found %0b",
                                 want.position, want.found, position, found);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_WRITE;
        entry_index <= '0;
        entry_value <= '0;
        search_key  <= '0;
        search_side <= SIDE_EXACT;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_ENTRIES_IN_USE;
        cfg_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_edges();
        test_unsorted_table();
        test_random_tables();
        test_full_table();
        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("sorted_table_binary_search test passed");
        else
            $display("sorted_table_binary_search test failed");
        $finish;
    end

endmodule
